FILE: rtl/bf3_pkg.sv
// shared types, constants and the reciprocal table of the 3x3 box filter
`default_nettype none

package bf3_pkg;

	localparam int PIX_BITS    = 16;
	localparam int CFG_BITS    = 11;
	localparam int SIDE_RESET  = 1024;
	localparam int FIFO_DEPTH  = 8;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_BITS  = 25;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// ceil(2^24 / n) for every neighbour count
	localparam logic [RECIP_BITS-1:0] RECIP_DIV1 = 25'd16777216;
	localparam logic [RECIP_BITS-1:0] RECIP_DIV2 = 25'd8388608;
	localparam logic [RECIP_BITS-1:0] RECIP_DIV3 = 25'd5592406;
	localparam logic [RECIP_BITS-1:0] RECIP_DIV4 = 25'd4194304;
	localparam logic [RECIP_BITS-1:0] RECIP_DIV6 = 25'd2796203;
	localparam logic [RECIP_BITS-1:0] RECIP_DIV9 = 25'd1864136;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} border_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] red;
		logic [PIX_BITS-1:0] green;
		logic [PIX_BITS-1:0] blue;
		logic                last;
	} result_t;

	// reciprocal of rows * columns, rows and columns each 1 to 3
	function automatic logic [RECIP_BITS-1:0] recip(input logic [1:0] rows,
		input logic [1:0] cols);
		logic [3:0]            n;
		logic [RECIP_BITS-1:0] m;
		n = {2'b00, rows} * {2'b00, cols};
		case (n)
			4'd1:    m = RECIP_DIV1;
			4'd2:    m = RECIP_DIV2;
			4'd3:    m = RECIP_DIV3;
			4'd4:    m = RECIP_DIV4;
			4'd6:    m = RECIP_DIV6;
			4'd9:    m = RECIP_DIV9;
			default: m = RECIP_DIV1;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bf3_pixel_if.sv
// input pixel channel of the box filter
`default_nettype none

interface bf3_pixel_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [bf3_pkg::PIX_BITS-1:0] red_in;
	logic [bf3_pkg::PIX_BITS-1:0] green_in;
	logic [bf3_pkg::PIX_BITS-1:0] blue_in;

	modport source(output valid, output opcode, output red_in, output green_in,
		output blue_in, input ready);
	modport sink(input valid, input opcode, input red_in, input green_in,
		input blue_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/bf3_result_if.sv
// smoothed pixel channel of the box filter
`default_nettype none

interface bf3_result_if;
	logic                          valid;
	logic                          ready;
	logic [bf3_pkg::PIX_BITS-1:0] red_out;
	logic [bf3_pkg::PIX_BITS-1:0] green_out;
	logic [bf3_pkg::PIX_BITS-1:0] blue_out;
	logic                          frame_last;

	modport source(output valid, output red_out, output green_out, output blue_out,
		output frame_last, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out,
		input frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/box_filter_three_by_three.sv
// top level of the streaming 3x3 clipped-edge box filter
`default_nettype none

// Takes one RGB pixel per clock in raster order and returns, for each pixel, the
// truncated mean of each channel over its neighbours inside the image. A result
// appears once the pixel one row below and one column right of it has arrived,
// so results lag the input by image_side+1 transfers; after the last pixel of a
// frame, feed image_side+1 drain transfers (opcode 1) to flush the frame. The
// final result is flagged with frame_last and the next transfer starts a new
// frame. Sustained rate is one pixel per clock: the two line stores live in one
// dual-width memory that is read and written back at the same column once per
// pixel (forwarded when two transfers in a row hit the same column, which only
// happens at column zero: side one, or the first pixel after a frame ends).
// From acceptance the result passes the read, window shift, sum and reciprocal
// multiply registers on its way to the output queue.
// The input stalls only when the eight-entry output queue plus the items in
// flight would be full, i.e. when the output side holds off. No clearing pass
// after reset: line store entries are always written before they count.
// Writing image_side restarts the frame; do it only while the block is idle.

module box_filter_three_by_three #(
	parameter int MAX_SIDE     = 1024,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bf3_pkg::CFG_BITS-1:0]  cfg_data,
	bf3_pixel_if.sink                      pixel,
	bf3_result_if.source                   smoothed
);

	localparam int AW       = $clog2(MAX_SIDE);
	localparam int CW       = $clog2(MAX_SIDE + 2);
	localparam int CMP_W    = (CW > bf3_pkg::CFG_BITS) ? CW : bf3_pkg::CFG_BITS;
	localparam int SUM_W    = CHANNEL_BITS + 4;
	localparam int PROD_W   = SUM_W + bf3_pkg::RECIP_BITS;
	localparam int CRED_W   = $clog2(bf3_pkg::FIFO_DEPTH + 1);
	localparam int SIDE_RST = (bf3_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
		: bf3_pkg::SIDE_RESET;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] r;
		logic [CHANNEL_BITS-1:0] g;
		logic [CHANNEL_BITS-1:0] b;
	} px_t;

	// one memory word holds the column of both line stores
	typedef struct packed {
		px_t upper;
		px_t lower;
	} pair_t;

	// side register, clamped when written
	logic [CW-1:0]    side_q;
	logic [CW-1:0]    side_m1_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [CW-1:0]    side_d;

	// raster counters
	logic [CW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;

	// accept stage
	logic             acc;
	logic [CW-1:0]    ic;
	logic [CW-1:0]    ic_inc;
	logic             col_wrap;
	logic             emit0;
	logic             last0;
	bf3_pkg::border_t border0;
	px_t              px0;
	logic [AW-1:0]    addr0;

	// memory stage
	pair_t            line_mem [MAX_SIDE];
	pair_t            rd_word_q;
	pair_t            fwd_data_q;
	pair_t            rd_res;
	pair_t            wr_word;
	logic             s1_valid;
	logic             s1_emit;
	logic             s1_last;
	logic             s1_fwd;
	bf3_pkg::border_t s1_border;
	px_t              s1_px;
	logic [AW-1:0]    s1_addr;

	// window and sum stage
	px_t              win_q [3][3];
	logic             s2_valid;
	logic             s2_last;
	bf3_pkg::border_t s2_border;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	logic [1:0]       row_cnt;
	logic [1:0]       col_cnt;

	// multiply stages
	logic                             s3_valid;
	logic                             s3_last;
	logic [SUM_W-1:0]                 s3_sum_r;
	logic [SUM_W-1:0]                 s3_sum_g;
	logic [SUM_W-1:0]                 s3_sum_b;
	logic [bf3_pkg::RECIP_BITS-1:0]  s3_recip;
	logic                             s4_valid;
	logic                             s4_last;
	logic [PROD_W-1:0]                s4_prod_r;
	logic [PROD_W-1:0]                s4_prod_g;
	logic [PROD_W-1:0]                s4_prod_b;

	// output queue and credits
	bf3_pkg::result_t push_data;
	bf3_pkg::result_t head;
	logic             q_not_empty;
	logic             pop;
	logic             drop;
	logic [CRED_W-1:0] used_q;

	// ---------------------------------------------------------------- config
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == '0) begin
			side_d = CW'(1);
		end else if (cfg_ext > CMP_W'(MAX_SIDE)) begin
			side_d = CW'(MAX_SIDE);
		end else begin
			side_d = CW'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= CW'(SIDE_RST);
			side_m1_q <= CW'(SIDE_RST - 1);
		end else if (cfg_we) begin
			side_q    <= side_d;
			side_m1_q <= side_d - CW'(1);
		end
	end

	// ---------------------------------------------------------------- accept
	// credits cover every item from acceptance until it leaves the queue
	assign pixel.ready = (used_q < CRED_W'(bf3_pkg::FIFO_DEPTH));
	assign acc         = pixel.valid && pixel.ready;

	always_comb begin
		ic       = (in_col_q >= side_q) ? '0 : in_col_q;
		ic_inc   = ic + CW'(1);
		col_wrap = (ic == side_m1_q);
		addr0    = ic[AW-1:0];
		// first result once the pixel right-below of the top-left one is in
		emit0    = (in_row_q >= CW'(2)) || ((in_row_q == CW'(1)) && (ic != '0));
		last0    = (out_row_q >= side_m1_q) && (out_col_q >= side_m1_q);
		border0.top    = (out_row_q != '0);
		border0.bottom = (out_row_q < side_m1_q);
		border0.left   = (out_col_q != '0);
		border0.right  = (out_col_q < side_m1_q);
		// a drain transfer counts as a black pixel
		if (pixel.opcode == bf3_pkg::OP_DRAIN) begin
			px0 = '0;
		end else begin
			px0.r = pixel.red_in[CHANNEL_BITS-1:0];
			px0.g = pixel.green_in[CHANNEL_BITS-1:0];
			px0.b = pixel.blue_in[CHANNEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (acc) begin
			in_col_q <= col_wrap ? '0 : ic_inc;
			in_row_q <= col_wrap ? in_row_q + CW'(1) : in_row_q;
			if (emit0) begin
				if (last0) begin
					// frame done, next transfer is the first pixel of a new one
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (out_col_q == side_m1_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + CW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- memory
	// read data of a back-to-back access to the same column comes from the
	// write that lands on the same edge as the read
	assign rd_res  = s1_fwd ? fwd_data_q : rd_word_q;
	assign wr_word = '{upper: rd_res.lower, lower: s1_px};

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			line_mem[s1_addr] <= wr_word;
		end
		if (acc) begin
			rd_word_q <= line_mem[addr0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_px      <= px0;
			s1_addr    <= addr0;
			s1_emit    <= emit0;
			s1_last    <= last0;
			s1_border  <= border0;
			s1_fwd     <= s1_valid && (s1_addr == addr0);
			fwd_data_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= acc;
		end
	end

	// ---------------------------------------------------------------- window
	always_ff @(posedge clk) begin
		if (s1_valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_res.upper;
			win_q[1][2] <= rd_res.lower;
			win_q[2][2] <= s1_px;
		end
	end

	always_ff @(posedge clk) begin
		s2_border <= s1_border;
		s2_last   <= s1_last;
	end

	// masked neighbourhood sums
	always_comb begin
		row_ok = {s2_border.bottom, 1'b1, s2_border.top};
		col_ok = {s2_border.right, 1'b1, s2_border.left};
		sum_r  = '0;
		sum_g  = '0;
		sum_b  = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_r = sum_r + SUM_W'(win_q[r][c].r);
					sum_g = sum_g + SUM_W'(win_q[r][c].g);
					sum_b = sum_b + SUM_W'(win_q[r][c].b);
				end
			end
		end
		row_cnt = 2'd1 + {1'b0, s2_border.top} + {1'b0, s2_border.bottom};
		col_cnt = 2'd1 + {1'b0, s2_border.left} + {1'b0, s2_border.right};
	end

	always_ff @(posedge clk) begin
		s3_sum_r <= sum_r;
		s3_sum_g <= sum_g;
		s3_sum_b <= sum_b;
		s3_recip <= bf3_pkg::recip(row_cnt, col_cnt);
		s3_last  <= s2_last;
	end

	// divide by the count as a multiply by its rounded-up reciprocal
	always_ff @(posedge clk) begin
		s4_prod_r <= PROD_W'(s3_sum_r) * PROD_W'(s3_recip);
		s4_prod_g <= PROD_W'(s3_sum_g) * PROD_W'(s3_recip);
		s4_prod_b <= PROD_W'(s3_sum_b) * PROD_W'(s3_recip);
		s4_last   <= s3_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
			s4_valid <= 1'b0;
		end else begin
			s2_valid <= s1_valid && s1_emit;
			s3_valid <= s2_valid;
			s4_valid <= s3_valid;
		end
	end

	// ---------------------------------------------------------------- output
	always_comb begin
		push_data.red   = bf3_pkg::PIX_BITS'(s4_prod_r[bf3_pkg::RECIP_SHIFT +: CHANNEL_BITS]);
		push_data.green = bf3_pkg::PIX_BITS'(s4_prod_g[bf3_pkg::RECIP_SHIFT +: CHANNEL_BITS]);
		push_data.blue  = bf3_pkg::PIX_BITS'(s4_prod_b[bf3_pkg::RECIP_SHIFT +: CHANNEL_BITS]);
		push_data.last  = s4_last;
	end

	bf3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s4_valid),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty)
	);

	assign smoothed.valid      = q_not_empty;
	assign smoothed.red_out    = head.red;
	assign smoothed.green_out  = head.green;
	assign smoothed.blue_out   = head.blue;
	assign smoothed.frame_last = head.last;

	assign pop  = smoothed.valid && smoothed.ready;
	// items without a result give their credit back after the memory stage
	assign drop = s1_valid && !s1_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_q + CRED_W'(acc) - CRED_W'(drop) - CRED_W'(pop);
		end
	end

	// ---------------------------------------------------------------- checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CRED_W'(bf3_pkg::FIFO_DEPTH))
		else $error("credit count above queue depth");

	a_fwd_column_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_fwd) |-> (s1_addr == '0))
		else $error("same-column forward away from column zero");

	a_result_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_emit) |=> ##2 s4_valid)
		else $error("result lost between memory stage and queue");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit0 && last0) |=> ((in_row_q == '0) && (in_col_q == '0)
		&& (out_row_q == '0) && (out_col_q == '0)))
		else $error("counters not cleared after last result of frame");

endmodule

`default_nettype wire

FILE: rtl/bf3_out_fifo.sv
// result queue between the filter pipeline and the output channel
`default_nettype none

module bf3_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bf3_pkg::result_t push_data,
	input  logic             pop,
	output bf3_pkg::result_t head,
	output logic             not_empty
);

	localparam int PTR_W = $clog2(bf3_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(bf3_pkg::FIFO_DEPTH + 1);

	bf3_pkg::result_t slot_q [bf3_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire
